@@ rtl/gdr_pkg.sv @@
// shared types, constants and helpers for the grid dda column raycaster
// no dependencies; imported by every module of the block
`default_nettype none
package gdr_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAP_DIM   = 32;
    localparam int MAP_AW    = $clog2(MAP_DIM);
    localparam int MAP_DEPTH = MAP_DIM * MAP_DIM;
    localparam int MAP_IW    = 2 * MAP_AW;
    localparam int STEP_CAP  = 2 * MAP_DIM;
    localparam int STEP_W    = $clog2(STEP_CAP + 1);
    localparam int GRID_W    = MAP_AW + 3;

    localparam int DIV_W     = 36;
    localparam int DIV_CW    = $clog2(DIV_W + 1);
    localparam int DELTA_W   = FRAC_BITS + 13;
    localparam int CAM_W     = 31;
    localparam int RAY_W     = 34;
    localparam int DIST_W    = 36;
    localparam int LINE_W    = 16;

    localparam logic [DIV_W-1:0] DELTA_CAP = DIV_W'(1) << (FRAC_BITS + 12);
    localparam logic [DIV_W-1:0] LINE_CAP  = DIV_W'(65535);
    localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(1) << (2 * FRAC_BITS);

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    localparam logic [2:0] CFG_POS_X   = 3'd0;
    localparam logic [2:0] CFG_POS_Y   = 3'd1;
    localparam logic [2:0] CFG_DIR_X   = 3'd2;
    localparam logic [2:0] CFG_DIR_Y   = 3'd3;
    localparam logic [2:0] CFG_PLANE_X = 3'd4;
    localparam logic [2:0] CFG_PLANE_Y = 3'd5;
    localparam logic [2:0] CFG_COLS    = 3'd6;
    localparam logic [2:0] CFG_ROWS    = 3'd7;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              wr_en;
        logic [MAP_IW-1:0] wr_addr;
        logic [2:0]        wr_data;
        logic              rd_en;
        logic [MAP_IW-1:0] rd_addr;
    } map_req_t;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_CAM  = 11'b00000000010,
        S_RAY  = 11'b00000000100,
        S_DX   = 11'b00000001000,
        S_DY   = 11'b00000010000,
        S_SIDE = 11'b00000100000,
        S_STEP = 11'b00001000000,
        S_TEST = 11'b00010000000,
        S_HDIV = 11'b00100000000,
        S_SPAN = 11'b01000000000,
        S_DONE = 11'b10000000000
    } state_t;

    function automatic logic [23:0] code_color(input logic [2:0] code);
        logic [23:0] c;
        case (code)
            3'd1:    c = 24'hff0000;
            3'd2:    c = 24'h178c05;
            3'd3:    c = 24'h0055ff;
            3'd4:    c = 24'hffffff;
            default: c = 24'hffff00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

@@ rtl/gdr_div.sv @@
// restoring unsigned divider, one quotient bit per cycle
// depends on gdr_pkg; a zero divisor gives an all-ones quotient
`default_nettype none
module gdr_div (
    input  wire                      clk,
    input  wire                      rst_n,
    input  gdr_pkg::div_req_t        req,
    output logic                     done,
    output logic [gdr_pkg::DIV_W-1:0] quotient
);
    import gdr_pkg::*;

    logic [DIV_W:0]    rem_reg, rem_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DIV_W-1:0]  den_reg, den_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_W:0]    shifted;
    logic              fits;

    always_comb
    begin
        shifted   = {rem_reg[DIV_W-1:0], quo_reg[DIV_W-1]};
        fits      = shifted >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
            cnt_next  = DIV_CW'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? (shifted - {1'b0, den_reg}) : shifted;
            quo_next = {quo_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

@@ rtl/gdr_map.sv @@
// map cell memory, one write and one registered read port
// depends on gdr_pkg; sweeps every entry to zero after reset
`default_nettype none
module gdr_map (
    input  wire                 clk,
    input  wire                 rst_n,
    input  gdr_pkg::map_req_t   req,
    output logic [2:0]          rd_data,
    output logic                clr_busy
);
    import gdr_pkg::*;

    logic [2:0]        mem [MAP_DEPTH];
    logic [2:0]        rd_data_reg;
    logic [MAP_IW-1:0] clr_cnt_reg;
    logic              clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == MAP_IW'(MAP_DEPTH - 1))
                clr_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
            mem[clr_cnt_reg] <= 3'd0;
        else if (req.wr_en)
            mem[req.wr_addr] <= req.wr_data;
        if (req.rd_en)
            rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;
endmodule
`default_nettype wire

@@ rtl/grid_dda_column_raycaster.sv @@
// sequence: a map write is written as it is accepted; a cast runs four divisions on the shared
// divider (camera, two reciprocals, line height) and walks at most 64 dda steps, each through
// S_STEP and S_TEST; a walk that runs out of steps skips the height division and goes to S_DONE
// throughput: one request at a time; the next is taken while a result waits in the output register
// reset: rst_n clears control and loads camera registers; the map then clears every entry,
// during which no request is taken (configuration writes are taken)
`default_nettype none
module grid_dda_column_raycaster (
    input  wire         clk,
    input  wire         rst_n,
    // configuration write channel
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [2:0]  cfg_addr,
    input  wire  [20:0] cfg_data,
    // request stream
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,  // column_index[11:0], cell_row[16:12], cell_col[21:17], cell_code[24:22], zero pad
    input  wire         s_tuser,  // cmd
    // result stream
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [63:0] m_tdata,  // out_column[11:0], span_start[23:12], span_end[35:24],
                                  // wall_color[59:36], hit_side[60], hit_code[63:61]
    output logic        m_tuser   // no_hit
);
    import gdr_pkg::*;

    // camera registers
    logic [20:0] pos_x_reg, pos_y_reg;
    logic signed [17:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [11:0] cols_reg, rows_reg;
    logic [11:0] cols_eff, rows_eff;

    // sequencer state
    state_t state_reg, state_next;
    div_req_t div_req_reg, div_req_next;
    map_req_t map_req;
    logic div_done;
    logic [DIV_W-1:0] div_q;
    logic [2:0] map_rd;
    logic map_busy;

    // per-cast working registers
    logic [11:0] col_reg, col_next;
    logic signed [CAM_W-1:0] cam_reg, cam_next;
    logic signed [RAY_W-1:0] rx_reg, rx_next, ry_reg, ry_next;
    logic [DELTA_W-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic [DIST_W-1:0] sx_reg, sx_next, sy_reg, sy_next;
    logic signed [GRID_W-1:0] gx_reg, gx_next, gy_reg, gy_next;
    logic [STEP_W-1:0] n_reg, n_next;
    logic side_reg, side_next;
    logic inrng_reg, inrng_next;
    logic [2:0] code_reg, code_next;
    logic [LINE_W-1:0] h_reg, h_next;
    logic [63:0] res_reg, res_next;
    logic res_nohit_reg, res_nohit_next;

    // output register
    logic m_tvalid_reg, m_tvalid_next;
    logic [63:0] m_tdata_reg, m_tdata_next;
    logic m_tuser_reg, m_tuser_next;

    // datapath intermediates
    logic accept;
    logic signed [48:0] prod_x, prod_y;
    logic [RAY_W-1:0] abs_ry;
    logic [DELTA_W-1:0] delta_sat;
    logic [16:0] frac_x, frac_y;
    logic [45:0] side_px, side_py;
    logic take_x;
    logic signed [GRID_W-1:0] gx_step, gy_step;
    logic [2:0] walk_code;
    logic [DIST_W-1:0] perp;
    logic [14:0] half_h;
    logic [10:0] half_rows;
    logic [14:0] s0_full;
    logic [15:0] s1_sum;
    logic [11:0] span_s0, span_s1;
    logic [23:0] color;

    // magnitude of a freshly formed ray component
    function automatic logic [RAY_W-1:0] abs_rx_from(input logic signed [RAY_W-1:0] v);
        return v[RAY_W-1] ? RAY_W'(-v) : RAY_W'(v);
    endfunction

    assign cfg_ready = 1'b1;
    assign cols_eff  = (cols_reg == 12'd0) ? 12'd1 : cols_reg;
    assign rows_eff  = (rows_reg == 12'd0) ? 12'd1 : rows_reg;
    assign s_tready  = (state_reg == S_IDLE) && !map_busy;
    assign accept    = s_tvalid && s_tready;

    // configuration writes; unknown indexes cannot occur with a three-bit index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg   <= 21'd1441792;
            pos_y_reg   <= 21'd786432;
            dir_x_reg   <= -18'sd65536;
            dir_y_reg   <= 18'sd0;
            plane_x_reg <= 18'sd0;
            plane_y_reg <= 18'sd43254;
            cols_reg    <= 12'd600;
            rows_reg    <= 12'd600;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_addr)
                CFG_POS_X:   pos_x_reg   <= cfg_data;
                CFG_POS_Y:   pos_y_reg   <= cfg_data;
                CFG_DIR_X:   dir_x_reg   <= cfg_data[17:0];
                CFG_DIR_Y:   dir_y_reg   <= cfg_data[17:0];
                CFG_PLANE_X: plane_x_reg <= cfg_data[17:0];
                CFG_PLANE_Y: plane_y_reg <= cfg_data[17:0];
                CFG_COLS:    cols_reg    <= cfg_data[11:0];
                default:     rows_reg    <= cfg_data[11:0];
            endcase
        end
    end

    // shared datapath pieces
    always_comb
    begin
        // ray = dir + floor(plane * cam / 2^F)
        prod_x = plane_x_reg * cam_reg;
        prod_y = plane_y_reg * cam_reg;
        abs_ry = ry_reg[RAY_W-1] ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);
        // reciprocal saturation, also covers a zero divisor
        delta_sat = (div_q > DELTA_CAP) ? DELTA_CAP[DELTA_W-1:0] : div_q[DELTA_W-1:0];
        // distance to first grid line in the step direction
        frac_x  = rx_reg[RAY_W-1] ? {1'b0, pos_x_reg[15:0]} : 17'h10000 - {1'b0, pos_x_reg[15:0]};
        frac_y  = ry_reg[RAY_W-1] ? {1'b0, pos_y_reg[15:0]} : 17'h10000 - {1'b0, pos_y_reg[15:0]};
        side_px = frac_x * dx_reg;
        side_py = frac_y * dy_reg;
        // dda step: ties go to y
        take_x  = sx_reg < sy_reg;
        gx_step = rx_reg[RAY_W-1] ? gx_reg - 1'b1 : gx_reg + 1'b1;
        gy_step = ry_reg[RAY_W-1] ? gy_reg - 1'b1 : gy_reg + 1'b1;
        // cells outside the grid read as empty
        walk_code = inrng_reg ? map_rd : 3'd0;
        perp    = side_reg ? (sy_reg - DIST_W'(dy_reg)) : (sx_reg - DIST_W'(dx_reg));
        // span from halved line height and screen height
        half_h    = h_reg[15:1];
        half_rows = rows_eff[11:1];
        s0_full   = (15'(half_rows) > half_h) ? 15'(half_rows) - half_h : 15'd0;
        span_s0   = s0_full[11:0];
        s1_sum    = {1'b0, half_h} + 16'(half_rows);
        span_s1   = (s1_sum >= 16'(rows_eff)) ? rows_eff - 12'd1 : s1_sum[11:0];
        color     = side_reg ? (code_color(code_reg) >> 1) : code_color(code_reg);
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        div_req_next   = '0;
        col_next       = col_reg;
        cam_next       = cam_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        gx_next        = gx_reg;
        gy_next        = gy_reg;
        n_next         = n_reg;
        side_next      = side_reg;
        inrng_next     = inrng_reg;
        code_next      = code_reg;
        h_next         = h_reg;
        res_next       = res_reg;
        res_nohit_next = res_nohit_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        map_req        = '0;
        map_req.wr_addr = {s_tdata[16:12], s_tdata[21:17]};
        map_req.wr_data = s_tdata[24:22];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (s_tuser == CMD_WRITE)
                        map_req.wr_en = 1'b1;
                    else
                    begin
                        col_next              = s_tdata[11:0];
                        div_req_next.start    = 1'b1;
                        div_req_next.dividend = DIV_W'({s_tdata[11:0], 1'b0, 16'd0});
                        div_req_next.divisor  = DIV_W'(cols_eff);
                        state_next            = S_CAM;
                    end
                end
            end
            S_CAM:
            begin
                if (div_done)
                begin
                    cam_next   = $signed({2'b00, div_q[28:0]}) - CAM_W'(65536);
                    state_next = S_RAY;
                end
            end
            S_RAY:
            begin
                rx_next    = RAY_W'(dir_x_reg) + RAY_W'(prod_x >>> FRAC_BITS);
                ry_next    = RAY_W'(dir_y_reg) + RAY_W'(prod_y >>> FRAC_BITS);
                state_next = S_DX;
                div_req_next.start    = 1'b1;
                div_req_next.dividend = RECIP_NUM;
                div_req_next.divisor  = DIV_W'(abs_rx_from(rx_next));
            end
            S_DX:
            begin
                if (div_done)
                begin
                    dx_next               = delta_sat;
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = RECIP_NUM;
                    div_req_next.divisor  = DIV_W'(abs_ry);
                    state_next            = S_DY;
                end
            end
            S_DY:
            begin
                if (div_done)
                begin
                    dy_next    = delta_sat;
                    state_next = S_SIDE;
                end
            end
            S_SIDE:
            begin
                sx_next    = DIST_W'(side_px[45:FRAC_BITS]);
                sy_next    = DIST_W'(side_py[45:FRAC_BITS]);
                gx_next    = GRID_W'(pos_x_reg[20:16]);
                gy_next    = GRID_W'(pos_y_reg[20:16]);
                n_next     = '0;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (take_x)
                begin
                    sx_next   = sx_reg + DIST_W'(dx_reg);
                    gx_next   = gx_step;
                    side_next = 1'b0;
                end
                else
                begin
                    sy_next   = sy_reg + DIST_W'(dy_reg);
                    gy_next   = gy_step;
                    side_next = 1'b1;
                end
                inrng_next      = (gx_next[GRID_W-1:MAP_AW] == '0) &&
                                  (gy_next[GRID_W-1:MAP_AW] == '0);
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = {gx_next[MAP_AW-1:0], gy_next[MAP_AW-1:0]};
                n_next          = n_reg + 1'b1;
                state_next      = S_TEST;
            end
            S_TEST:
            begin
                if (walk_code != 3'd0)
                begin
                    code_next             = walk_code;
                    div_req_next.start    = 1'b1;
                    div_req_next.dividend = DIV_W'({rows_eff, 16'd0});
                    div_req_next.divisor  = perp;
                    state_next            = S_HDIV;
                end
                else if (n_reg == STEP_W'(STEP_CAP))
                begin
                    res_next       = {52'd0, col_reg};
                    res_nohit_next = 1'b1;
                    state_next     = S_DONE;
                end
                else
                    state_next = S_STEP;
            end
            S_HDIV:
            begin
                if (div_done)
                begin
                    // a zero distance divides to all ones and saturates here
                    h_next     = (div_q > LINE_CAP) ? LINE_CAP[LINE_W-1:0] : div_q[LINE_W-1:0];
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                res_next       = {code_reg, side_reg, color, span_s1, span_s0, col_reg};
                res_nohit_next = 1'b0;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = res_nohit_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            div_req_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            div_req_reg  <= div_req_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg       <= col_next;
        cam_reg       <= cam_next;
        rx_reg        <= rx_next;
        ry_reg        <= ry_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sx_reg        <= sx_next;
        sy_reg        <= sy_next;
        gx_reg        <= gx_next;
        gy_reg        <= gy_next;
        n_reg         <= n_next;
        side_reg      <= side_next;
        inrng_reg     <= inrng_next;
        code_reg      <= code_next;
        h_reg         <= h_next;
        res_reg       <= res_next;
        res_nohit_reg <= res_nohit_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    gdr_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    gdr_map u_map (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (map_req),
        .rd_data  (map_rd),
        .clr_busy (map_busy)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
endmodule
`default_nettype wire
